// ----- src/kavf_pkg.sv -----
// kavf_pkg: shared types and constants for the altitude/velocity kalman filter
// no dependencies
`default_nettype none
package kavf_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned DtW   = 16;
    localparam int unsigned VarW  = 31;
    localparam int unsigned SigW  = 24;
    localparam int unsigned AddrW = 3;

    localparam logic [AddrW-1:0] RegAltSigma = 3'd0;
    localparam logic [AddrW-1:0] RegStartAlt = 3'd4;

    localparam logic signed [31:0] CovStart = 32'sd655360;
    localparam logic [23:0]        SigmaReset = 24'd65536;

    // datapath micro operations
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_MUL   = 4'd1,   // acc <= qmul(a, b)
        OP_LOAD  = 4'd2,   // reg[dst] <= qmul(a, b)
        OP_ADD   = 4'd3,   // reg[dst] <= sat(reg[a] + reg[b] + acc)
        OP_SUB   = 4'd4,   // reg[dst] <= sat(reg[a] - reg[b] - acc)
        OP_DIVS  = 4'd5,   // start divider: num reg[a], den l
        OP_DIVW  = 4'd6,   // wait divider, write reg[dst]
        OP_SETUP = 4'd7,   // no datapath action; dt derived terms are computed on input load
        OP_QTERM = 4'd8,   // compute q terms from scratch
        OP_LSET  = 4'd9,   // l = p00 + r, clamped
        OP_OUT   = 4'd10,  // load output register
        OP_ACC   = 4'd11   // acc <= acc + reg[a] + reg[b], kept exact
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] dst;
        logic       acc_clr;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/kavf_if.sv -----
// kavf_if: valid/ready stream interfaces for samples and results
// depends on kavf_pkg
`default_nettype none
interface kavf_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] vertical_accel;
    logic signed [31:0] measured_altitude;
    logic [15:0] time_step;
    modport source (output valid, vertical_accel, measured_altitude, time_step, input ready);
    modport sink (input valid, vertical_accel, measured_altitude, time_step, output ready);
endinterface

interface kavf_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] altitude_estimate;
    logic signed [31:0] velocity_estimate;
    logic [30:0] altitude_variance;
    modport source (output valid, altitude_estimate, velocity_estimate, altitude_variance,
        input ready);
    modport sink (input valid, altitude_estimate, velocity_estimate, altitude_variance,
        output ready);
endinterface
`default_nettype wire

// ----- src/kalman_altitude_velocity_fusion.sv -----
// kalman_altitude_velocity_fusion: top level, apb registers, ctrl and datapath
// depends on kavf_pkg, kavf_if, kavf_ctrl, kavf_datapath
//
// channel   dir  payload
// smp       in   vertical_accel, measured_altitude, time_step
// res       out  altitude_estimate, velocity_estimate, altitude_variance
// apb       in   altitude_sigma @0x0, start_altitude @0x4
//
// one sample runs from idle through the program steps, issued one a cycle to a
// shared 32x32 multiplier except while the divider is waited on, two serial
// gain divisions with a 48 bit quotient, and the output state. a stalled sink
// holds the program at its last step until the previous result is taken;
// input is accepted only when idle. rst_n clears altitude and velocity and sets
// covariance 10.0; a start_altitude write restarts from that altitude.
`default_nettype none
module kalman_altitude_velocity_fusion #(
    parameter int unsigned ACCEL_SIGMA = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    kavf_in_if.sink                 smp,
    kavf_out_if.source              res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import kavf_pkg::*;

    logic [23:0]        sigma_reg;
    logic signed [31:0] start_reg;
    logic               wr;
    logic               restart;
    cmd_t               cmd;
    stat_t              stat;
    logic               load_in;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign restart = wr && (paddr == RegStartAlt);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SigmaReset;
            start_reg <= '0;
        end
        else if (wr)
        begin
            if (paddr == RegAltSigma) sigma_reg <= pwdata[23:0];
            if (paddr == RegStartAlt) start_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (paddr)
            RegAltSigma: prdata = {8'd0, sigma_reg};
            RegStartAlt: prdata = start_reg;
            default:     prdata = '0;
        endcase
    end

    kavf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp.valid),
        .in_ready  (smp.ready),
        .load_in   (load_in),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    kavf_datapath #(.ACCEL_SIGMA(ACCEL_SIGMA)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .load_in   (load_in),
        .in_accel  (smp.vertical_accel),
        .in_meas   (smp.measured_altitude),
        .in_dt     (smp.time_step),
        .restart   (restart),
        .start_alt (pwdata),
        .sigma     (sigma_reg),
        .alt_o     (res.altitude_estimate),
        .vel_o     (res.velocity_estimate),
        .var_o     (res.altitude_variance)
    );
endmodule
`default_nettype wire

// ----- src/kavf_div.sv -----
// kavf_div: restoring divider, (num*65536)/den truncated, saturated to int32
// depends on kavf_pkg
`default_nettype none
module kavf_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic [32:0]        den,
    output logic                    busy,
    output logic signed [31:0]      quo
);
    import kavf_pkg::*;

    logic [47:0] n_reg, n_next;
    logic [47:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;
    logic signed [49:0] sq;

    // one quotient bit per cycle, busy after start until all 48 quotient bits are done
    always_comb
    begin
        n_next = n_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = '0;
        if (start)
        begin
            neg_next = num[31];
            n_next = {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            den_next = den;
            rem_next = '0;
            q_next = '0;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, n_reg[47]} - {1'b0, den_reg};
            n_next = {n_reg[46:0], 1'b0};
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], n_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign sq = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign quo = sat32(66'(sq));
    assign busy = busy_reg;
endmodule
`default_nettype wire

// ----- src/kavf_datapath.sv -----
// kavf_datapath: register file, shared multiplier, adder and divider
// depends on kavf_pkg, kavf_div
`default_nettype none
module kavf_datapath #(
    parameter int unsigned ACCEL_SIGMA = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kavf_pkg::cmd_t       cmd,
    output kavf_pkg::stat_t           stat,
    input  wire logic                 load_in,
    input  wire logic signed [31:0]   in_accel,
    input  wire logic signed [31:0]   in_meas,
    input  wire logic [15:0]          in_dt,
    input  wire logic                 restart,
    input  wire logic signed [31:0]   start_alt,
    input  wire logic [23:0]          sigma,
    output logic signed [31:0]        alt_o,
    output logic signed [31:0]        vel_o,
    output logic [30:0]               var_o
);
    import kavf_pkg::*;

    localparam logic [19:0] Var = 20'(ACCEL_SIGMA * ACCEL_SIGMA);

    // register file: 0 alt, 1 vel, 2 p00, 3 p01, 4 p11 (state); rest scratch
    logic signed [31:0] rf_reg [0:15];
    logic signed [34:0] acc_reg;
    logic signed [32:0] l_reg;
    logic signed [31:0] r_reg;
    logic               start_div;
    logic signed [31:0] quo;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [31:0] qm;
    logic [31:0]        sq;
    logic signed [65:0] s;
    logic signed [47:0] qt;
    logic [47:0]        s2;
    logic signed [33:0] lsum;
    logic               div_busy;

    assign ma = rf_reg[cmd.a[3:0]];
    assign mb = rf_reg[cmd.b[3:0]];
    assign prod = ma * mb;
    assign qm = sat32(66'((prod + 64'sd32768) >>> 16));
    assign sq = {16'd0, in_dt} * {16'd0, in_dt};
    assign s2 = {24'd0, sigma} * {24'd0, sigma};
    assign lsum = 34'(rf_reg[2]) + 34'(r_reg);

    always_comb
    begin
        s = '0;
        qt = '0;
        case (cmd.op)
            OP_ADD:   s = 66'(ma) + 66'(mb) + 66'(acc_reg);
            OP_ACC:   s = 66'(ma) + 66'(mb) + 66'(acc_reg);
            OP_SUB:   s = 66'(ma) - 66'(mb) - 66'(acc_reg);
            OP_QTERM: qt = 48'(ma) * $signed({1'b0, Var});
            default:  s = '0;
        endcase
    end

    assign start_div = (cmd.op == OP_DIVS);

    kavf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_div),
        .num   (ma),
        .den   (l_reg[32:0]),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign stat.div_busy = div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg[0] <= '0;
            rf_reg[1] <= '0;
            rf_reg[2] <= CovStart;
            rf_reg[3] <= '0;
            rf_reg[4] <= CovStart;
            for (int i = 5; i < 16; i++) rf_reg[i] <= '0;
            acc_reg <= '0;
            l_reg <= 33'sd1;
            r_reg <= '0;
            alt_o <= '0;
            vel_o <= '0;
            var_o <= '0;
        end
        else if (restart)
        begin
            rf_reg[0] <= start_alt;
            rf_reg[1] <= '0;
            rf_reg[2] <= CovStart;
            rf_reg[3] <= '0;
            rf_reg[4] <= CovStart;
        end
        else if (load_in)
        begin
            rf_reg[5] <= in_accel;
            rf_reg[6] <= in_meas;
            rf_reg[7] <= {16'd0, in_dt};
            rf_reg[8] <= 32'((sq + 32'd32768) >> 16);
            rf_reg[9] <= 32'((33'(sq) + 33'd65536) >> 17);
            r_reg <= (((s2 + 48'd32768) >> 16) > 48'h7fffffff) ? 32'sh7fffffff
                     : 32'(((s2 + 48'd32768) >> 16));
        end
        else
        begin
            case (cmd.op)
                OP_MUL:  acc_reg <= 35'(qm);
                OP_LOAD: rf_reg[cmd.dst[3:0]] <= qm;
                OP_ADD:
                begin
                    rf_reg[cmd.dst[3:0]] <= sat32(s);
                    if (cmd.acc_clr) acc_reg <= '0;
                end
                OP_ACC:  acc_reg <= s[34:0];
                OP_SUB:  rf_reg[cmd.dst[3:0]] <= sat32(s);
                OP_QTERM:
                begin
                    if (cmd.b == 5'd2)
                        rf_reg[cmd.dst[3:0]] <= sat32(66'((qt + 48'sd2) >>> 2));
                    else if (cmd.b == 5'd1)
                        rf_reg[cmd.dst[3:0]] <= sat32(66'((qt + 48'sd1) >>> 1));
                    else
                        rf_reg[cmd.dst[3:0]] <= sat32(66'(qt));
                end
                OP_LSET: l_reg <= (lsum < 34'sd1) ? 33'sd1 : lsum[32:0];
                OP_DIVW:
                    if (!div_busy) rf_reg[cmd.dst[3:0]] <= quo;
                OP_OUT:
                begin
                    alt_o <= rf_reg[0];
                    vel_o <= rf_reg[1];
                    var_o <= rf_reg[2][31] ? '0 : rf_reg[2][30:0];
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/kavf_ctrl.sv -----
// kavf_ctrl: sequencer stepping through the predict and update program
// depends on kavf_pkg
`default_nettype none
module kavf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                load_in,
    output logic                out_valid,
    input  wire logic           out_ready,
    output kavf_pkg::cmd_t      cmd,
    input  wire kavf_pkg::stat_t stat
);
    import kavf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] pc_reg, pc_next;
    logic       ov_reg, ov_next;
    logic       last;

    // scratch: 5 acc 6 meas 7 dt 8 dt2 9 dt2h 10..15 temps
    always_comb
    begin
        cmd = '{op: OP_NOP, a: 5'd0, b: 5'd0, dst: 5'd0, acc_clr: 1'b0};
        last = 1'b0;
        if (state_reg == ST_RUN || state_reg == ST_WAIT)
        begin
            case (pc_reg)
                6'd0:  cmd = '{OP_LOAD, 5'd8, 5'd7, 5'd10, 1'b0};   // dt3
                6'd1:  cmd = '{OP_LOAD, 5'd8, 5'd8, 5'd11, 1'b0};   // dt4
                6'd2:  cmd = '{OP_QTERM, 5'd11, 5'd2, 5'd11, 1'b0}; // q00
                6'd3:  cmd = '{OP_QTERM, 5'd10, 5'd1, 5'd10, 1'b0}; // q01
                6'd4:  cmd = '{OP_QTERM, 5'd8, 5'd0, 5'd12, 1'b0};  // q11
                6'd5:  cmd = '{OP_LOAD, 5'd7, 5'd1, 5'd13, 1'b0};   // dt*v
                6'd6:  cmd = '{OP_MUL, 5'd9, 5'd5, 5'd0, 1'b0};     // dt2h*a
                6'd7:  cmd = '{OP_ADD, 5'd0, 5'd13, 5'd0, 1'b1};
                6'd8:  cmd = '{OP_MUL, 5'd7, 5'd5, 5'd0, 1'b0};
                6'd9:  cmd = '{OP_ADD, 5'd1, 5'd15, 5'd1, 1'b1};   // r15 is zero
                6'd10: cmd = '{OP_LOAD, 5'd7, 5'd3, 5'd13, 1'b0};  // t
                6'd11: cmd = '{OP_LOAD, 5'd8, 5'd4, 5'd14, 1'b0};  // dt2*p11
                6'd12: cmd = '{OP_ACC, 5'd13, 5'd13, 5'd0, 1'b0};  // acc = 2t
                6'd13: cmd = '{OP_ACC, 5'd14, 5'd15, 5'd0, 1'b0};  // acc += dt2*p11
                6'd14: cmd = '{OP_ADD, 5'd2, 5'd11, 5'd2, 1'b1};   // p00 new
                6'd15: cmd = '{OP_NOP, 5'd0, 5'd0, 5'd0, 1'b0};
                6'd16: cmd = '{OP_NOP, 5'd0, 5'd0, 5'd0, 1'b0};
                6'd17: cmd = '{OP_MUL, 5'd7, 5'd4, 5'd0, 1'b0};
                6'd18: cmd = '{OP_ADD, 5'd3, 5'd10, 5'd3, 1'b1};   // p01 new
                6'd19: cmd = '{OP_ADD, 5'd4, 5'd12, 5'd4, 1'b1};   // p11 new
                6'd20: cmd = '{OP_LSET, 5'd0, 5'd0, 5'd0, 1'b0};
                6'd21: cmd = '{OP_DIVS, 5'd2, 5'd0, 5'd0, 1'b0};
                6'd22: cmd = '{OP_DIVW, 5'd0, 5'd0, 5'd10, 1'b0};  // k0
                6'd23: cmd = '{OP_DIVS, 5'd3, 5'd0, 5'd0, 1'b0};
                6'd24: cmd = '{OP_DIVW, 5'd0, 5'd0, 5'd11, 1'b0};  // k1
                6'd25: cmd = '{OP_NOP, 5'd0, 5'd0, 5'd0, 1'b0};
                6'd26: cmd = '{OP_NOP, 5'd0, 5'd0, 5'd0, 1'b0};
                6'd27: cmd = '{OP_SUB, 5'd6, 5'd0, 5'd12, 1'b0};   // y: acc is 0
                6'd28: cmd = '{OP_MUL, 5'd10, 5'd12, 5'd0, 1'b0};
                6'd29: cmd = '{OP_ADD, 5'd0, 5'd15, 5'd0, 1'b1};
                6'd30: cmd = '{OP_MUL, 5'd11, 5'd12, 5'd0, 1'b0};
                6'd31: cmd = '{OP_ADD, 5'd1, 5'd15, 5'd1, 1'b1};
                6'd32: cmd = '{OP_MUL, 5'd11, 5'd3, 5'd0, 1'b0};
                6'd33: cmd = '{OP_SUB, 5'd4, 5'd15, 5'd4, 1'b0};
                6'd34: cmd = '{OP_MUL, 5'd10, 5'd3, 5'd0, 1'b0};
                6'd35: cmd = '{OP_SUB, 5'd3, 5'd15, 5'd3, 1'b0};
                6'd36: cmd = '{OP_MUL, 5'd10, 5'd2, 5'd0, 1'b0};
                6'd37: cmd = '{OP_SUB, 5'd2, 5'd15, 5'd2, 1'b0};
                6'd38:
                begin
                    // hold here while the previous result still waits
                    if (!ov_reg || out_ready)
                    begin
                        cmd = '{OP_OUT, 5'd0, 5'd0, 5'd0, 1'b0};
                        last = 1'b1;
                    end
                end
                default: cmd = '{OP_NOP, 5'd0, 5'd0, 5'd0, 1'b0};
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign load_in = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        ov_next = ov_reg;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (load_in)
                begin
                    state_next = ST_RUN;
                    pc_next = '0;
                end
            ST_RUN:
            begin
                if (cmd.op == OP_DIVS) state_next = ST_WAIT;
                if (last)
                begin
                    state_next = ST_OUT;
                end
                pc_next = pc_reg + 6'd1;
                if (pc_reg == 6'd38) pc_next = pc_reg;
            end
            ST_WAIT:
                if (!stat.div_busy)
                begin
                    state_next = ST_RUN;
                    pc_next = pc_reg + 6'd1;
                end
            ST_OUT:
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

// ----- src/kavf_checker.sv -----
// kavf_checker: port level checks bound to the top level
// depends on kalman_altitude_velocity_fusion ports
`default_nettype none
module kavf_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [31:0] out_alt
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_alt))
        else $error("result changed under stall");
    // no sample taken in the cycle right after one
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back to back sample accepted");
    // a result never appears right after a sample transfer
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");
endmodule

bind kalman_altitude_velocity_fusion kavf_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (smp.valid),
    .in_ready  (smp.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_alt   (res.altitude_estimate)
);
`default_nettype wire
